// ===== src/dasu_pkg.sv =====
// shared types, codes and helpers of the address register step unit
`default_nettype none

package dasu_pkg;

    // operation carried by an input word
    typedef enum logic [1:0]
    {
        MODE_STEP   = 2'd0,
        MODE_OFFSET = 2'd1,
        MODE_LOAD   = 2'd2,
        MODE_RAW    = 2'd3
    } mode_t;

    // configuration register indexes
    typedef enum logic [2:0]
    {
        CFG_MOD_ENABLE     = 3'd0,
        CFG_BITREV_ENABLE  = 3'd1,
        CFG_UNIT0          = 3'd2,
        CFG_UNIT1          = 3'd3,
        CFG_STEP_REG_UNIT0 = 3'd4,
        CFG_STEP_REG_UNIT1 = 3'd5,
        CFG_STEP_CONTROL   = 3'd6,
        CFG_MODULO_DISABLE = 3'd7
    } cfg_index_t;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int IN_DATA_WIDTH   = 40;

    // step_control low field value that picks the 16-bit step register
    localparam logic [1:0] STEP_SEL_REG = 2'd1;

    // constant steps that are split into two half steps under modulo
    localparam logic signed [2:0] CST_PLUS2  = 3'sb010;
    localparam logic signed [2:0] CST_MINUS2 = 3'sb110;

    // one input word, unpacked
    typedef struct packed
    {
        mode_t              mode;
        logic [2:0]         reg_index;
        logic signed [2:0]  step_const;
        logic               use_step_reg;
        logic signed [7:0]  offset_amount;
        logic [15:0]        load_value;
    } item_t;

    // configuration state seen by the datapath
    typedef struct packed
    {
        logic [7:0]         mod_enable;
        logic [7:0]         bitrev_enable;
        logic [1:0][15:0]   cfg_unit;
        logic [1:0][15:0]   step_reg_unit;
        logic [3:0]         step_control;
        logic               modulo_disable;
    } cfg_t;

    // modulo window mask: smallest power of two, at least 2, not below end, minus one
    function automatic logic [8:0] wrap_mask9(input logic [8:0] end9);
        logic [8:0] x;
        x = end9 - 9'd1;
        x = x | (x >> 1);
        x = x | (x >> 2);
        x = x | (x >> 4);
        x = x | (x >> 8);
        if (end9 <= 9'd2)
        begin
            x = 9'd1;
        end
        return x;
    endfunction

endpackage

`default_nettype wire

// ===== src/dasu_cfg_regs.sv =====
// configuration register bank written through the configuration channel
`default_nettype none

module dasu_cfg_regs
    import dasu_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output cfg_t                            cfg
);

    cfg_t cfg_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MOD_ENABLE:     cfg_reg.mod_enable       <= cfg_data[7:0];
                CFG_BITREV_ENABLE:  cfg_reg.bitrev_enable    <= cfg_data[7:0];
                CFG_UNIT0:          cfg_reg.cfg_unit[0]      <= cfg_data;
                CFG_UNIT1:          cfg_reg.cfg_unit[1]      <= cfg_data;
                CFG_STEP_REG_UNIT0: cfg_reg.step_reg_unit[0] <= cfg_data;
                CFG_STEP_REG_UNIT1: cfg_reg.step_reg_unit[1] <= cfg_data;
                CFG_STEP_CONTROL:   cfg_reg.step_control     <= cfg_data[3:0];
                CFG_MODULO_DISABLE: cfg_reg.modulo_disable   <= cfg_data[0];
                default:            cfg_reg                  <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/dasu_calc.sv =====
// address arithmetic: bit reversal, plain and modulo post-modify, offset and load
`default_nettype none

module dasu_calc
    import dasu_pkg::*;
#(
    parameter int ADDR_WIDTH = 16
)
(
    input  wire item_t                   item,
    input  wire cfg_t                    cfg,
    input  wire logic [ADDR_WIDTH-1:0]   reg_value,
    output logic [ADDR_WIDTH-1:0]        result,
    output logic                         wr_en,
    output logic [ADDR_WIDTH-1:0]        wr_value
);

    localparam int EW = ADDR_WIDTH + 9;

    logic                       unit;
    logic                       md;
    logic                       br;
    logic                       br_only;
    logic                       plain;
    logic                       dbl;
    logic                       clear;
    logic [8:0]                 end9;
    logic [ADDR_WIDTH-1:0]      mask_a;
    logic [ADDR_WIDTH-1:0]      rev;
    logic [ADDR_WIDTH-1:0]      sel_value;
    logic signed [16:0]         step_v;
    logic signed [16:0]         half_v;
    logic signed [16:0]         off_v;
    logic [ADDR_WIDTH-1:0]      half_once;
    logic [ADDR_WIDTH-1:0]      step_next;

    // wrapping add of a signed amount
    function automatic logic [ADDR_WIDTH-1:0] add_signed(
        input logic [ADDR_WIDTH-1:0] r,
        input logic signed [16:0]    v
    );
        logic [EW-1:0] sum;
        sum = EW'(r) + EW'(v);
        return sum[ADDR_WIDTH-1:0];
    endfunction

    // one move inside the modulo window
    function automatic logic [ADDR_WIDTH-1:0] mod_move(
        input logic [ADDR_WIDTH-1:0] r,
        input logic signed [16:0]    v,
        input logic [ADDR_WIDTH-1:0] mask,
        input logic [8:0]            e
    );
        logic [ADDR_WIDTH-1:0] low;
        logic                  at_end;
        logic [ADDR_WIDTH-1:0] moved;
        low    = r & mask;
        at_end = (EW'(low) == EW'(e));
        moved  = add_signed(r, v);
        if (!v[16] && (v != '0) && at_end)
        begin
            moved = r & ~mask;
        end
        else if (v[16] && (low == '0))
        begin
            moved = (r & ~mask) | ADDR_WIDTH'(e);
        end
        return moved;
    endfunction

    // per-register flags and unit window
    always_comb
    begin
        unit    = item.reg_index[2];
        md      = cfg.mod_enable[item.reg_index];
        br      = cfg.bitrev_enable[item.reg_index];
        br_only = br && !md;
        plain   = !md || br || cfg.modulo_disable;
        end9    = cfg.cfg_unit[unit][15:7];
        mask_a  = ADDR_WIDTH'(wrap_mask9(end9));
    end

    // bit-reversed view of the register
    always_comb
    begin
        for (int k = 0; k < ADDR_WIDTH; k++)
        begin
            rev[k] = reg_value[ADDR_WIDTH-1-k];
        end
        sel_value = br_only ? rev : reg_value;
    end

    // step amount selection
    always_comb
    begin
        dbl   = !item.use_step_reg &&
                ((item.step_const == CST_PLUS2) || (item.step_const == CST_MINUS2));
        clear = (item.reg_index[1:0] == 2'b11) && cfg.step_control[2 + int'(unit)] && !dbl;
        if (!item.use_step_reg)
        begin
            step_v = {{14{item.step_const[2]}}, item.step_const};
        end
        else if ((cfg.step_control[1:0] == STEP_SEL_REG) || br_only)
        begin
            if (md)
            begin
                step_v = {{8{cfg.step_reg_unit[unit][8]}}, cfg.step_reg_unit[unit][8:0]};
            end
            else
            begin
                step_v = {cfg.step_reg_unit[unit][15], cfg.step_reg_unit[unit]};
            end
        end
        else
        begin
            step_v = {{10{cfg.cfg_unit[unit][6]}}, cfg.cfg_unit[unit][6:0]};
        end
        half_v = step_v[16] ? 17'h1FFFF : 17'h00001;
        off_v  = {{9{item.offset_amount[7]}}, item.offset_amount};
    end

    // post-modified register value
    always_comb
    begin
        half_once = mod_move(reg_value, half_v, mask_a, end9);
        if (clear)
        begin
            step_next = '0;
        end
        else if (plain)
        begin
            step_next = add_signed(reg_value, step_v);
        end
        else if (dbl)
        begin
            step_next = mod_move(half_once, half_v, mask_a, end9);
        end
        else
        begin
            step_next = mod_move(reg_value, step_v, mask_a, end9);
        end
    end

    // result and register write per operation
    always_comb
    begin
        wr_en    = 1'b0;
        wr_value = step_next;
        case (item.mode)
            MODE_STEP:
            begin
                result = sel_value;
                wr_en  = 1'b1;
            end
            MODE_OFFSET:
            begin
                result = plain ? add_signed(sel_value, off_v)
                               : mod_move(reg_value, off_v, mask_a, end9);
            end
            MODE_LOAD:
            begin
                result   = ADDR_WIDTH'(item.load_value);
                wr_en    = 1'b1;
                wr_value = ADDR_WIDTH'(item.load_value);
            end
            default:
            begin
                result = reg_value;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/dsp_address_register_step_unit.sv =====
// Address register step unit of a DSP address generator.
//
// Input words arrive on s_tvalid/s_tready/s_tdata; each carries a step,
// offset, load or raw-read operation on one of the address registers.
// Every word gives exactly one address word on m_tvalid/m_tready/m_tdata.
// Configuration registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high, and writes are meant to
// happen while no word is in flight.
// An accepted word is registered in the input register and its address
// then in the result register, which drives m_tdata; an output stall can
// hold the word in between. While m_tready stays high, throughput is one
// word per cycle: the register read, the add with its wrap compare and
// the register write-back all sit between the input and result registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more word; s_tready drops only when both hold.
// Reset clears all address registers, all configuration registers and both
// valid flags; no word is pending after reset.
`default_nettype none

module dsp_address_register_step_unit
    import dasu_pkg::*;
#(
    parameter int NUM_ADDR_REGS = 8,
    parameter int ADDR_WIDTH    = 16
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // mode[1:0], reg_index[4:2], step_const[7:5], use_step_reg[8],
    // offset_amount[16:9], load_value[32:17], zero pad
    input  wire logic [IN_DATA_WIDTH-1:0]         s_tdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // address[ADDR_WIDTH-1:0], zero pad to whole bytes
    output logic [((ADDR_WIDTH + 7) / 8) * 8-1:0] m_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0]       cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]        cfg_data
);

    localparam int OUT_DATA_WIDTH = ((ADDR_WIDTH + 7) / 8) * 8;
    localparam int IW = (NUM_ADDR_REGS > 1) ? $clog2(NUM_ADDR_REGS) : 1;

    cfg_t                       cfg;
    item_t                      in_item;
    item_t                      in_item_reg;
    logic                       in_valid_reg;
    logic                       advance;
    logic                       reg_valid;
    logic [IW-1:0]              reg_idx;
    logic [ADDR_WIDTH-1:0]      reg_value;
    logic [ADDR_WIDTH-1:0]      result;
    logic                       wr_en;
    logic [ADDR_WIDTH-1:0]      wr_value;
    logic [ADDR_WIDTH-1:0]      out_data_reg;
    logic                       out_valid_reg;
    logic [ADDR_WIDTH-1:0]      addr_file_reg [NUM_ADDR_REGS];

    // configuration bank
    dasu_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // unpack the input word
    assign in_item.mode          = mode_t'(s_tdata[1:0]);
    assign in_item.reg_index     = s_tdata[4:2];
    assign in_item.step_const    = s_tdata[7:5];
    assign in_item.use_step_reg  = s_tdata[8];
    assign in_item.offset_amount = s_tdata[16:9];
    assign in_item.load_value    = s_tdata[32:17];

    // handshake between the two register stages
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= in_item;
        end
    end

    // register file read
    assign reg_valid = (32'(in_item_reg.reg_index) < NUM_ADDR_REGS);
    assign reg_idx   = IW'(in_item_reg.reg_index);
    assign reg_value = reg_valid ? addr_file_reg[reg_idx] : '0;

    dasu_calc #(.ADDR_WIDTH(ADDR_WIDTH)) u_calc
    (
        .item      (in_item_reg),
        .cfg       (cfg),
        .reg_value (reg_value),
        .result    (result),
        .wr_en     (wr_en),
        .wr_value  (wr_value)
    );

    // register file write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_ADDR_REGS; k++)
            begin
                addr_file_reg[k] <= '0;
            end
        end
        else if (advance && wr_en && reg_valid)
        begin
            addr_file_reg[reg_idx] <= wr_value;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_WIDTH'(out_data_reg);

    // a load word echoes its value as the address
    a_load_echo: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_item_reg.mode == MODE_LOAD)
        |=> out_data_reg == ADDR_WIDTH'($past(in_item_reg.load_value)))
        else $error("load word did not return its value");

    // a held input word is never dropped
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending input word lost");

    // every word moved forward shows up as a result
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result word missing after advance");

    // a load to a present register is visible in the register file
    a_load_write: assert property (@(posedge clk) disable iff (!rst_n)
        advance && reg_valid && (in_item_reg.mode == MODE_LOAD)
        |=> addr_file_reg[$past(reg_idx)] == ADDR_WIDTH'($past(in_item_reg.load_value)))
        else $error("load did not update address register");

endmodule

`default_nettype wire
